FILE: rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg - shared definitions for the radix digit emitter
// Conversion kind codes, field widths and the digit character lookup.
// ----------------------------------------------------------------------------
package rde_pkg;

	localparam int DEFAULT_VALUE_BITS = 64;

	localparam int VALUE_W = 64;
	localparam int KIND_W  = 3;
	localparam int CHAR_W  = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_OCT    = 3'd0,
		KIND_HEX_LO = 3'd1,
		KIND_PTR    = 3'd2,
		KIND_HEX_UP = 3'd3,
		KIND_DEC    = 3'd4,
		KIND_BIN    = 3'd5
	} kind_t;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
	localparam logic [CHAR_W-1:0] CHAR_A_LO  = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_A_UP  = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

	// ascii for one digit 0..15, letters in either case
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else if (upper) begin
			c = CHAR_A_UP + CHAR_W'(d - 4'd10);
		end else begin
			c = CHAR_A_LO + CHAR_W'(d - 4'd10);
		end
		return c;
	endfunction

endpackage

FILE: rtl/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter - integer to ascii text in several radices
// Digit-serial conversion of a 64-bit integer to octal, hex, pointer,
// decimal or binary text, one character per output item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one number per item: s_axis_tdata is the value, s_axis_tuser
//   the conversion kind and the length modifier flag. m_axis returns the text,
//   one character per item, most significant digit first, tlast on the final
//   character. An unsupported kind returns one item with tuser (no text) set.
//   One item is converted at a time; s_axis_tready is high only when the
//   previous conversion has handed its last character to the output register.
//   Octal, hex and binary walk a shift register one digit per cycle from the
//   top; leading zeros are skipped, and a character waits while the output
//   register holds one not yet taken. The pointer kind first emits its 0x
//   prefix. Decimal first runs a shift-and-add-3 pass, one input bit per
//   cycle, then walks the bcd digits (20 for 64 bits). Each character passes
//   through the output register. A stalled receiver freezes the character
//   walk; leading-zero skipping goes on.
//   Reset empties the output register and returns the block to idle.
// ----------------------------------------------------------------------------
module radix_digit_emitter
	import rde_pkg::*;
#(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // value[63:0]
	input  logic [3:0]  s_axis_tuser,   // conversion_kind[2:0], has_length_modifier[3]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // character[6:0], zero[7]
	output logic        m_axis_tuser,   // no_text[0]
	output logic        m_axis_tlast
);

	localparam int OCT_D  = (VALUE_BITS + 2) / 3;
	localparam int HEX_D  = (VALUE_BITS + 3) / 4;
	localparam int DEC_D  = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int XW     = (3 * OCT_D > 4 * HEX_D) ? 3 * OCT_D : 4 * HEX_D;
	localparam int BW     = 4 * DEC_D;
	localparam int RW     = $clog2(VALUE_BITS + 1);
	localparam int OCT_SH = XW - 3 * OCT_D;
	localparam int HEX_SH = XW - 4 * HEX_D;
	localparam int BIN_SH = XW - VALUE_BITS;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DABBLE = 6'b000010,
		ST_PFX0   = 6'b000100,
		ST_PFXX   = 6'b001000,
		ST_DIGITS = 6'b010000,
		ST_NONE   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		RAD_BIN = 2'd0,
		RAD_OCT = 2'd1,
		RAD_HEX = 2'd2,
		RAD_DEC = 2'd3
	} rad_t;

	state_t            state_q;
	rad_t              rad_q;
	logic              upper_q;
	logic              started_q;
	logic [RW-1:0]     rem_q;
	logic [XW-1:0]     ext_q;
	logic [BW-1:0]     bcd_q;

	logic              o_valid_q;
	logic [CHAR_W-1:0] o_char_q;
	logic              o_last_q;
	logic              o_none_q;

	logic              in_acc;
	logic              out_free;
	kind_t             in_kind;
	logic              in_mod;
	logic [63:0]       num;
	logic [VALUE_BITS-1:0] num_m;
	logic [XW-1:0]     ext_bin;
	logic [3:0]        digit;
	logic [XW-1:0]     ext_shift;
	logic [BW-1:0]     bcd_adj;
	logic              skip;
	logic              emit;

	assign in_kind  = kind_t'(s_axis_tuser[2:0]);
	assign in_mod   = s_axis_tuser[3];
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !o_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	// 32-bit rules without a length modifier
	always_comb begin
		num = s_axis_tdata;
		if (!in_mod && num[63]) begin
			num = {32'd0, s_axis_tdata[31:0]};
		end
		if (!in_mod && num == 64'h0000_0001_0000_0000) begin
			num = 64'd0;
		end
		num_m   = num[VALUE_BITS-1:0];
		ext_bin = XW'(num_m);
	end

	// top digit and one-digit shift of the walk
	always_comb begin
		unique case (rad_q)
			RAD_BIN: begin
				digit     = {3'd0, ext_q[XW-1]};
				ext_shift = ext_q << 1;
			end
			RAD_OCT: begin
				digit     = {1'b0, ext_q[XW-1 -: 3]};
				ext_shift = ext_q << 3;
			end
			RAD_HEX: begin
				digit     = ext_q[XW-1 -: 4];
				ext_shift = ext_q << 4;
			end
			RAD_DEC: begin
				digit     = bcd_q[BW-1 -: 4];
				ext_shift = ext_q;
			end
			default: begin
				digit     = 4'd0;
				ext_shift = ext_q;
			end
		endcase
		skip = !started_q && digit == 4'd0 && rem_q != RW'(1);
	end

	// an item goes into the output register this cycle
	always_comb begin
		unique case (state_q)
			ST_PFX0, ST_PFXX, ST_NONE: begin
				emit = out_free;
			end
			ST_DIGITS: begin
				emit = out_free && !skip;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// add 3 to every bcd digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DEC_D; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                             : bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			o_valid_q <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (emit) begin
				o_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						started_q <= 1'b0;
						unique case (in_kind)
							KIND_OCT: begin
								state_q <= ST_DIGITS;
								rad_q   <= RAD_OCT;
								rem_q   <= RW'(OCT_D);
								ext_q   <= ext_bin << OCT_SH;
							end
							KIND_HEX_LO, KIND_HEX_UP: begin
								state_q <= ST_DIGITS;
								rad_q   <= RAD_HEX;
								upper_q <= (in_kind == KIND_HEX_UP);
								rem_q   <= RW'(HEX_D);
								ext_q   <= ext_bin << HEX_SH;
							end
							KIND_PTR: begin
								state_q <= ST_PFX0;
								rad_q   <= RAD_HEX;
								upper_q <= 1'b0;
								rem_q   <= RW'(HEX_D);
								ext_q   <= ext_bin << HEX_SH;
							end
							KIND_DEC: begin
								state_q <= ST_DABBLE;
								rad_q   <= RAD_DEC;
								rem_q   <= RW'(VALUE_BITS);
								ext_q   <= ext_bin << BIN_SH;
								bcd_q   <= '0;
							end
							KIND_BIN: begin
								state_q <= ST_DIGITS;
								rad_q   <= RAD_BIN;
								rem_q   <= RW'(VALUE_BITS);
								ext_q   <= ext_bin << BIN_SH;
							end
							default: begin
								state_q <= ST_NONE;
							end
						endcase
					end
				end
				ST_DABBLE: begin
					bcd_q <= {bcd_adj[BW-2:0], ext_q[XW-1]};
					ext_q <= ext_q << 1;
					if (rem_q == RW'(1)) begin
						state_q <= ST_DIGITS;
						rem_q   <= RW'(DEC_D);
					end else begin
						rem_q <= rem_q - RW'(1);
					end
				end
				ST_PFX0: begin
					if (out_free) begin
						o_char_q  <= CHAR_ZERO;
						o_last_q  <= 1'b0;
						o_none_q  <= 1'b0;
						state_q   <= ST_PFXX;
					end
				end
				ST_PFXX: begin
					if (out_free) begin
						o_char_q  <= CHAR_X;
						o_last_q  <= 1'b0;
						o_none_q  <= 1'b0;
						state_q   <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (skip || out_free) begin
						ext_q <= ext_shift;
						bcd_q <= bcd_q << 4;
						rem_q <= rem_q - RW'(1);
						if (!skip) begin
							started_q <= 1'b1;
							o_char_q  <= digit_char(digit, upper_q);
							o_last_q  <= (rem_q == RW'(1));
							o_none_q  <= 1'b0;
						end
						if (rem_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_NONE: begin
					if (out_free) begin
						o_char_q  <= CHAR_NONE;
						o_last_q  <= 1'b1;
						o_none_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = {1'b0, o_char_q};
	assign m_axis_tuser  = o_none_q;
	assign m_axis_tlast  = o_last_q;

	// no-text item carries a zero character and closes its conversion
	a_none_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0 && m_axis_tlast)
		else $error("no-text item with character or without last");

	a_unsupported: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tuser[2:0] > 3'd5 |=> state_q == ST_NONE)
		else $error("unsupported kind did not lead to the no-text item");

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGITS |-> rem_q != '0)
		else $error("digit walk with no digits left");

	a_dabble_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DABBLE && rem_q == RW'(1) |=>
			state_q == ST_DIGITS && rem_q == RW'(DEC_D))
		else $error("bcd pass did not hand over to the digit walk");

endmodule
